>>> design/mcid_pkg.sv
// Package for the motor command input decoder.
// Holds the configuration struct, opcodes, register indexes and field widths.
// No dependencies.
package mcid_pkg;

  // Field widths
  localparam int unsigned PosW    = 32;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned DutyW   = 12;
  localparam int unsigned CpsW    = 16;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned RegIdxW = 3;

  // Event opcodes
  localparam logic [1:0] OP_ENABLE = 2'd0;
  localparam logic [1:0] OP_STEP   = 2'd1;
  localparam logic [1:0] OP_PWM    = 2'd2;

  // Register indexes (byte address = 4 * index)
  localparam logic [RegIdxW-1:0] REG_ENA_INVERT   = 3'd0;
  localparam logic [RegIdxW-1:0] REG_DIR_INVERT   = 3'd1;
  localparam logic [RegIdxW-1:0] REG_COUNTS_STEP  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_CHOP_PERIOD  = 3'd3;
  localparam logic [RegIdxW-1:0] REG_MIN_DUTY     = 3'd4;

  // Reset values
  localparam logic [CpsW-1:0]  CpsReset  = 16'd1;
  localparam logic [DutyW-1:0] ChopReset = 12'd1024;

  // Configuration handed from the register block to the core
  typedef struct packed {
    logic             ena_invert;
    logic             dir_invert;
    logic [CpsW-1:0]  counts_per_step;
    logic [DutyW-1:0] chopper_period;
    logic [DutyW-1:0] min_duty;
  } cfg_t;

endpackage

>>> design/motor_command_input_decoder_top.sv
// Top level of the motor command input decoder.
// Instantiates mcid_regs and mcid_div; depends on mcid_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one event: enable change,
//   step edge or pwm capture, with the raw pin levels and captured times.
//   Output channel (out_valid_o / out_ready_i) returns one result transaction
//   per event: position target, running flag, start/stop pulses, duty.
//   Configuration goes through the APB-style port, registers at 4*index.
// Flow: enable and step events pass from acceptance through the done state
//   into the output register. A pwm capture with period above high time runs
//   the shared multiply and 12-step serial divider in the calc state first;
//   other pwm captures go straight to the done state. One event is in work at
//   a time; the divider loop sets the rate for pwm captures.
// The output register holds a finished result while the receiver stalls;
//   the next event may be accepted then, and its result waits in the core
//   until the output register frees.
// Reset clears position target, running flag and last direction, and
//   loads the register defaults.
module motor_command_input_decoder_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mcid_pkg::AddrW-1:0]        paddr,
  input  logic [mcid_pkg::DataW-1:0]        pwdata,
  output logic [mcid_pkg::DataW-1:0]        prdata,
  output logic                              pready,
  // Input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        opcode_i,
  input  logic                              ena_pin_i,
  input  logic                              dir_pin_i,
  input  logic signed [mcid_pkg::PosW-1:0]  encoder_position_i,
  input  logic [mcid_pkg::TimeW-1:0]        pwm_high_time_i,
  input  logic [mcid_pkg::TimeW-1:0]        pwm_period_time_i,
  // Output channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [mcid_pkg::PosW-1:0]  requested_position_o,
  output logic                              running_o,
  output logic                              start_pulse_o,
  output logic                              stop_pulse_o,
  output logic [mcid_pkg::DutyW-1:0]        duty_o,
  output logic                              duty_valid_o,
  output logic                              recommutate_o
);
  import mcid_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  cfg_t              cfg;
  logic [1:0]        state_q, state_d;
  logic              accept;
  logic              ena, dir;
  logic              need_div;
  logic              div_done;
  logic [DutyW-1:0]  quot;
  logic [DutyW-1:0]  quot_clamped;
  logic              out_free;

  // Architectural state
  logic [PosW-1:0]   pos_q, pos_d;
  logic              motor_on_q, motor_on_d;
  logic              last_dir_q, last_dir_d;

  // Pending result
  logic              res_start_q, res_start_d;
  logic              res_stop_q, res_stop_d;
  logic              res_valid_q, res_valid_d;
  logic              res_recomm_q, res_recomm_d;
  logic [DutyW-1:0]  res_duty_q, res_duty_d;

  // Output register
  logic              out_valid_q;
  logic [PosW-1:0]   out_pos_q;
  logic              out_run_q, out_start_q, out_stop_q;
  logic [DutyW-1:0]  out_duty_q;
  logic              out_dv_q, out_recomm_q;

  mcid_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign ena        = ena_pin_i ^ cfg.ena_invert;
  assign dir        = dir_pin_i ^ cfg.dir_invert;
  assign need_div   = (opcode_i == OP_PWM) && (pwm_period_time_i > pwm_high_time_i);
  assign out_free   = ~out_valid_q | out_ready_i;

  mcid_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept & need_div),
    .chop_i   (cfg.chopper_period),
    .high_i   (pwm_high_time_i),
    .period_i (pwm_period_time_i),
    .done_o   (div_done),
    .quot_o   (quot)
  );

  assign quot_clamped = (quot < cfg.min_duty) ? cfg.min_duty : quot;

  // Event decode on acceptance and duty fill-in when the divider finishes
  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    motor_on_d   = motor_on_q;
    last_dir_d   = last_dir_q;
    res_start_d  = res_start_q;
    res_stop_d   = res_stop_q;
    res_valid_d  = res_valid_q;
    res_recomm_d = res_recomm_q;
    res_duty_d   = res_duty_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_start_d  = 1'b0;
          res_stop_d   = 1'b0;
          res_valid_d  = 1'b0;
          res_recomm_d = 1'b0;
          res_duty_d   = '0;
          state_d      = ST_DONE;
          case (opcode_i)
            OP_ENABLE: begin
              if (ena && !motor_on_q) begin
                pos_d       = $unsigned(encoder_position_i);
                motor_on_d  = 1'b1;
                res_start_d = 1'b1;
              end else if (!ena && motor_on_q) begin
                motor_on_d = 1'b0;
                res_stop_d = 1'b1;
              end
            end
            OP_STEP: begin
              pos_d = dir ? pos_q + PosW'(cfg.counts_per_step)
                          : pos_q - PosW'(cfg.counts_per_step);
            end
            OP_PWM: begin
              res_valid_d  = 1'b1;
              res_recomm_d = dir ^ last_dir_q;
              last_dir_d   = dir;
              res_duty_d   = cfg.min_duty;
              if (need_div) begin
                state_d = ST_CALC;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CALC: begin
        if (div_done) begin
          res_duty_d = quot_clamped;
          state_d    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      motor_on_q  <= 1'b0;
      last_dir_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      motor_on_q <= motor_on_d;
      last_dir_q <= last_dir_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pending result and output payload
  always_ff @(posedge clk_i) begin
    res_start_q  <= res_start_d;
    res_stop_q   <= res_stop_d;
    res_valid_q  <= res_valid_d;
    res_recomm_q <= res_recomm_d;
    res_duty_q   <= res_duty_d;
    if (state_q == ST_DONE && out_free) begin
      out_pos_q    <= pos_q;
      out_run_q    <= motor_on_q;
      out_start_q  <= res_start_q;
      out_stop_q   <= res_stop_q;
      out_duty_q   <= res_duty_q;
      out_dv_q     <= res_valid_q;
      out_recomm_q <= res_recomm_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign requested_position_o = $signed(out_pos_q);
  assign running_o            = out_run_q;
  assign start_pulse_o        = out_start_q;
  assign stop_pulse_o         = out_stop_q;
  assign duty_o               = out_duty_q;
  assign duty_valid_o         = out_dv_q;
  assign recommutate_o        = out_recomm_q;

endmodule

>>> design/mcid_regs.sv
// Configuration register block for the motor command input decoder.
// APB-style write/read port, always ready. Depends on mcid_pkg.
module mcid_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mcid_pkg::AddrW-1:0] paddr,
  input  logic [mcid_pkg::DataW-1:0] pwdata,
  output logic [mcid_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output mcid_pkg::cfg_t             cfg_o
);
  import mcid_pkg::*;

  cfg_t                cfg_q;
  logic                wr_en;
  logic [RegIdxW-1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[AddrW-1:2];

  // Register writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ena_invert      <= 1'b0;
      cfg_q.dir_invert      <= 1'b0;
      cfg_q.counts_per_step <= CpsReset;
      cfg_q.chopper_period  <= ChopReset;
      cfg_q.min_duty        <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ENA_INVERT:  cfg_q.ena_invert      <= pwdata[0];
        REG_DIR_INVERT:  cfg_q.dir_invert      <= pwdata[0];
        REG_COUNTS_STEP: cfg_q.counts_per_step <= pwdata[CpsW-1:0];
        REG_CHOP_PERIOD: cfg_q.chopper_period  <= pwdata[DutyW-1:0];
        REG_MIN_DUTY:    cfg_q.min_duty        <= pwdata[DutyW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_ENA_INVERT:  prdata[0]          = cfg_q.ena_invert;
      REG_DIR_INVERT:  prdata[0]          = cfg_q.dir_invert;
      REG_COUNTS_STEP: prdata[CpsW-1:0]   = cfg_q.counts_per_step;
      REG_CHOP_PERIOD: prdata[DutyW-1:0]  = cfg_q.chopper_period;
      REG_MIN_DUTY:    prdata[DutyW-1:0]  = cfg_q.min_duty;
      default: ;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/mcid_div.sv
// Shared duty unit: one 12x16 multiply on load, then a restoring divider
// that retires one quotient bit per cycle. Depends on mcid_pkg.
module mcid_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mcid_pkg::DutyW-1:0]  chop_i,
  input  logic [mcid_pkg::TimeW-1:0]  high_i,
  input  logic [mcid_pkg::TimeW-1:0]  period_i,
  output logic                        done_o,
  output logic [mcid_pkg::DutyW-1:0]  quot_o
);
  import mcid_pkg::*;

  // Caller guarantees high < period, so the quotient fits in DutyW bits
  // and the top TimeW bits of the product are already below the divisor.
  localparam int unsigned ProdW = DutyW + TimeW;
  localparam int unsigned CntW  = $clog2(DutyW + 1);

  logic [ProdW-1:0] prod;
  logic [TimeW-1:0] rem_q;
  logic [DutyW-1:0] low_q;
  logic [TimeW-1:0] div_q;
  logic [DutyW-1:0] quot_q;
  logic [CntW-1:0]  cnt_q;
  logic             active_q;
  logic             done_q;
  logic [TimeW:0]   trial;
  logic [TimeW:0]   diff;
  logic             fits;

  assign prod  = ProdW'(chop_i) * ProdW'(high_i);
  assign trial = {rem_q, low_q[DutyW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  // Sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= CntW'(DutyW);
      end else if (active_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  // Datapath: load product, then one restoring step per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= prod[ProdW-1:DutyW];
      low_q  <= prod[DutyW-1:0];
      div_q  <= period_i;
      quot_q <= '0;
    end else if (active_q) begin
      rem_q  <= fits ? diff[TimeW-1:0] : trial[TimeW-1:0];
      low_q  <= {low_q[DutyW-2:0], 1'b0};
      quot_q <= {quot_q[DutyW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> verif/tb_motor_command_input_decoder_top.sv
// Self-checking testbench for motor_command_input_decoder_top.
// Drives enable, step and pwm capture events and checks each result against a predictor.
// Depends on mcid_pkg and the design sources.
`timescale 1ns / 100ps

module tb_motor_command_input_decoder_top;
  import mcid_pkg::*;

  // Opcode 3 has no meaning in the design
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned MAX_REPORTS    = 40;

  typedef struct packed {
    logic [1:0]             opcode;
    logic                   ena;
    logic                   dir;
    logic signed [PosW-1:0] enc;
    logic [TimeW-1:0]       high;
    logic [TimeW-1:0]       period;
  } motor_cmd_t;

  typedef struct packed {
    logic signed [PosW-1:0] position;
    logic                   running;
    logic                   start_pulse;
    logic                   stop_pulse;
    logic [DutyW-1:0]       duty;
    logic                   duty_valid;
    logic                   recommutate;
  } drive_status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [1:0]             opcode_i = OP_ENABLE;
  logic                   ena_pin_i = 1'b0;
  logic                   dir_pin_i = 1'b0;
  logic signed [PosW-1:0] encoder_position_i = '0;
  logic [TimeW-1:0]       pwm_high_time_i = '0;
  logic [TimeW-1:0]       pwm_period_time_i = '0;

  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic signed [PosW-1:0] requested_position_o;
  logic                   running_o;
  logic                   start_pulse_o;
  logic                   stop_pulse_o;
  logic [DutyW-1:0]       duty_o;
  logic                   duty_valid_o;
  logic                   recommutate_o;

  // Predictor state and register shadow
  cfg_t        cfg_shadow = '{1'b0, 1'b0, CpsReset, ChopReset, '0};
  logic [31:0] target_pos = '0;
  logic        drive_on = 1'b0;
  logic        last_dir = 1'b0;

  motor_cmd_t    cmd_backlog[$];
  drive_status_t status_due[$];
  motor_cmd_t    offered;

  int unsigned outstanding = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  motor_command_input_decoder_top dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .opcode_i            (opcode_i),
    .ena_pin_i           (ena_pin_i),
    .dir_pin_i           (dir_pin_i),
    .encoder_position_i  (encoder_position_i),
    .pwm_high_time_i     (pwm_high_time_i),
    .pwm_period_time_i   (pwm_period_time_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .requested_position_o(requested_position_o),
    .running_o           (running_o),
    .start_pulse_o       (start_pulse_o),
    .stop_pulse_o        (stop_pulse_o),
    .duty_o              (duty_o),
    .duty_valid_o        (duty_valid_o),
    .recommutate_o       (recommutate_o)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Decode one command and advance the predicted drive state
  function automatic drive_status_t decode_command(input motor_cmd_t c);
    drive_status_t s;
    logic          ena;
    logic          dir;
    logic [31:0]   quot;
    s = '0;
    ena = c.ena ^ cfg_shadow.ena_invert;
    dir = c.dir ^ cfg_shadow.dir_invert;
    case (c.opcode)
      OP_ENABLE: begin
        if (ena && !drive_on) begin
          target_pos = c.enc;
          s.start_pulse = 1'b1;
          drive_on = 1'b1;
        end else if (!ena && drive_on) begin
          s.stop_pulse = 1'b1;
          drive_on = 1'b0;
        end
      end
      OP_STEP: begin
        // wraps in 32 bits
        if (dir) target_pos = target_pos + 32'(cfg_shadow.counts_per_step);
        else target_pos = target_pos - 32'(cfg_shadow.counts_per_step);
      end
      OP_PWM: begin
        s.duty_valid = 1'b1;
        s.recommutate = (dir != last_dir);
        last_dir = dir;
        if (c.period != '0 && c.period > c.high) begin
          quot = (32'(cfg_shadow.chopper_period) * 32'(c.high)) / 32'(c.period);
        end else begin
          quot = '0;
        end
        if (quot < 32'(cfg_shadow.min_duty)) quot = 32'(cfg_shadow.min_duty);
        s.duty = quot[DutyW-1:0];
      end
      default: ;
    endcase
    s.position = target_pos;
    s.running = drive_on;
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Input driver: holds each transaction until accepted, predicts on acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) status_due.push_back(decode_command(offered));
      if (!in_valid_i || in_ready_o) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = cmd_backlog.pop_front();
          in_valid_i <= 1'b1;
          opcode_i <= offered.opcode;
          ena_pin_i <= offered.ena;
          dir_pin_i <= offered.dir;
          encoder_position_i <= offered.enc;
          pwm_high_time_i <= offered.high;
          pwm_period_time_i <= offered.period;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down here
  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Receiver ready with random stalls
  always @(posedge clk_i) begin
    if (!rst_ni || hold_left != 0) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Result monitor
  always @(posedge clk_i) begin : status_check
    drive_status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_due.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = status_due.pop_front();
        compare_field("requested_position", requested_position_o, want.position);
        compare_field("running", 32'(running_o), 32'(want.running));
        compare_field("start_pulse", 32'(start_pulse_o), 32'(want.start_pulse));
        compare_field("stop_pulse", 32'(stop_pulse_o), 32'(want.stop_pulse));
        compare_field("duty", 32'(duty_o), 32'(want.duty));
        compare_field("duty_valid", 32'(duty_valid_o), 32'(want.duty_valid));
        compare_field("recommutate", 32'(recommutate_o), 32'(want.recommutate));
        outstanding--;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("motor_command_input_decoder_top verification failed");
      $finish;
    end
  end

  // Register write: setup cycle, then access cycle
  task automatic reg_write(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ENA_INVERT:  cfg_shadow.ena_invert = value[0];
      REG_DIR_INVERT:  cfg_shadow.dir_invert = value[0];
      REG_COUNTS_STEP: cfg_shadow.counts_per_step = value[CpsW-1:0];
      REG_CHOP_PERIOD: cfg_shadow.chopper_period = value[DutyW-1:0];
      REG_MIN_DUTY:    cfg_shadow.min_duty = value[DutyW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic ena_inv, input logic dir_inv,
                              input logic [CpsW-1:0] cps, input logic [DutyW-1:0] chop,
                              input logic [DutyW-1:0] min_d);
    reg_write(REG_ENA_INVERT, 32'(ena_inv));
    reg_write(REG_DIR_INVERT, 32'(dir_inv));
    reg_write(REG_COUNTS_STEP, 32'(cps));
    reg_write(REG_CHOP_PERIOD, 32'(chop));
    reg_write(REG_MIN_DUTY, 32'(min_d));
  endtask

  // Wait until every queued command has produced its result and been checked
  task automatic drain();
    do @(posedge clk_i);
    while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic enqueue(input motor_cmd_t c);
    cmd_backlog.push_back(c);
    outstanding++;
  endtask

  function automatic motor_cmd_t mk(input logic [1:0] op, input logic ena, input logic dir,
                                    input logic [31:0] enc, input logic [TimeW-1:0] high,
                                    input logic [TimeW-1:0] period);
    motor_cmd_t c;
    c.opcode = op;
    c.ena = ena;
    c.dir = dir;
    c.enc = enc;
    c.high = high;
    c.period = period;
    return c;
  endfunction

  // Random command; capture times mostly give a real division
  function automatic motor_cmd_t rand_cmd(input logic [1:0] op);
    motor_cmd_t  c;
    int unsigned shape;
    c.opcode = op;
    c.ena = 1'($urandom);
    c.dir = 1'($urandom);
    c.enc = $urandom;
    c.period = 16'($urandom);
    c.high = 16'($urandom);
    shape = $urandom_range(9);
    if (shape < 5) begin
      if (c.period == '0) c.period = 16'd1;
      c.high = 16'($urandom_range(c.period - 1));
    end else if (shape < 7) begin
      c.period = 16'($urandom_range(12, 1));
      c.high = 16'($urandom_range(c.period));
    end else if (shape == 7) begin
      c.period = '0;
    end else if (shape == 8) begin
      c.high = c.period;
    end
    return c;
  endfunction

  // Mostly enable-on / moves and captures / enable-off runs, with some noise
  task automatic queue_traffic(input int unsigned n_items);
    int unsigned queued;
    int unsigned len;
    motor_cmd_t  c;
    queued = 0;
    while (queued < n_items) begin
      if ($urandom_range(99) < 80) begin
        c = rand_cmd(OP_ENABLE);
        c.ena = ~cfg_shadow.ena_invert;
        enqueue(c);
        len = $urandom_range(12, 2);
        repeat (len) enqueue(rand_cmd($urandom_range(1) ? OP_STEP : OP_PWM));
        c = rand_cmd(OP_ENABLE);
        c.ena = cfg_shadow.ena_invert;
        enqueue(c);
        queued += len + 2;
      end else begin
        enqueue(rand_cmd(2'($urandom_range(3))));
        queued++;
      end
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed checks at reset configuration, no idling
    enqueue(mk(OP_STEP, 1'b0, 1'b0, 32'h0, 16'h0, 16'h0));          // wrap below zero
    enqueue(mk(OP_STEP, 1'b1, 1'b1, 32'h0, 16'h0, 16'h0));          // back to zero
    enqueue(mk(OP_ENABLE, 1'b0, 1'b0, 32'h1234_5678, 16'h0, 16'h0)); // low while stopped
    enqueue(mk(OP_ENABLE, 1'b1, 1'b1, 32'h7fff_ffff, 16'hffff, 16'hffff)); // start at max
    enqueue(mk(OP_ENABLE, 1'b1, 1'b0, 32'h0, 16'h0, 16'h0));        // already running
    enqueue(mk(OP_STEP, 1'b1, 1'b1, 32'h0, 16'h0, 16'h0));          // wrap to min
    enqueue(mk(OP_STEP, 1'b0, 1'b0, 32'h0, 16'h0, 16'h0));          // back to max
    enqueue(mk(OP_PWM, 1'b1, 1'b1, 32'h0, 16'h0000, 16'h0000));     // zero period, dir change
    enqueue(mk(OP_PWM, 1'b1, 1'b1, 32'h0, 16'h1234, 16'h1234));     // period equals high
    enqueue(mk(OP_PWM, 1'b1, 1'b0, 32'h0, 16'hffff, 16'h0001));     // high above period
    enqueue(mk(OP_PWM, 1'b1, 1'b0, 32'h0, 16'hfffe, 16'hffff));     // near full scale
    enqueue(mk(OP_PWM, 1'b1, 1'b0, 32'h0, 16'h0000, 16'h0001));     // zero high time
    enqueue(mk(OP_PWM, 1'b0, 1'b1, 32'h0, 16'h5555, 16'haaaa));
    enqueue(mk(OP_NONE, 1'b1, 1'b1, 32'hffff_ffff, 16'hffff, 16'hffff)); // unused opcode
    enqueue(mk(OP_ENABLE, 1'b0, 1'b0, 32'h0, 16'h0, 16'h0));        // stop
    enqueue(mk(OP_ENABLE, 1'b0, 1'b1, 32'h0, 16'h0, 16'h0));        // already stopped
    enqueue(mk(OP_ENABLE, 1'b1, 1'b1, 32'h8000_0000, 16'h0, 16'h0)); // start at min
    enqueue(mk(OP_STEP, 1'b1, 1'b0, 32'h0, 16'h0, 16'h0));          // wrap to max
    enqueue(mk(OP_ENABLE, 1'b0, 1'b1, 32'h0, 16'h0, 16'h0));        // stop
    queue_traffic(100);
    drain();

    // Largest step and chopper, sender idling
    send_idle_pct = 50;
    stall_pct = 0;
    program_regs(1'b1, 1'b0, 16'hffff, 12'hfff, 12'h000);
    queue_traffic(110);
    drain();

    // Zero step, smallest nonzero chopper, duty pinned at top; receiver stalling
    send_idle_pct = 0;
    stall_pct = 50;
    program_regs(1'b0, 1'b1, 16'h0000, 12'h001, 12'hfff);
    queue_traffic(110);
    drain();

    // Zero chopper period leaves only the minimum duty; both sides idle
    send_idle_pct = 28;
    stall_pct = 28;
    program_regs(1'b1, 1'b1, 16'h0001, 12'h000, 12'h011);
    queue_traffic(110);
    drain();

    // Receiver holds off while the sender keeps offering
    send_idle_pct = 0;
    stall_pct = 0;
    program_regs(1'b0, 1'b0, 16'($urandom), 12'($urandom_range(4095, 1)),
                 12'($urandom_range(200)));
    queue_traffic(60);
    @(posedge clk_i);
    hold_left <= HOLD_CYCLES;
    drain();

    // Random settings across all idle modes
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 50; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase
      program_regs(1'($urandom), 1'($urandom), 16'($urandom), 12'($urandom),
                   ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(200)));
      queue_traffic(100);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("motor_command_input_decoder_top verification clean");
    end else begin
      $display("motor_command_input_decoder_top verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/mcid_pkg.sv
design/mcid_regs.sv
design/mcid_div.sv
design/motor_command_input_decoder_top.sv
verif/tb_motor_command_input_decoder_top.sv
